FILE: hdl/lwhk_pkg.sv
package lwhk_pkg;

   localparam int CordicStages = 16;
   localparam int CordicIters = (CordicStages < 24) ? CordicStages : 24;
   localparam int QuatDelay = CordicIters + 3;
   localparam int AngW = 28;
   localparam int WrapW = AngW + 3;
   localparam int CW = 33;
   localparam int CsrIdxW = 3;

   localparam logic signed [AngW-1:0] AngPi = 28'sd52707179;
   localparam logic signed [AngW-1:0] AngHalfPi = 28'sd26353589;
   localparam logic signed [WrapW-1:0] WrapTwoPi = 31'sd105414357;
   localparam logic signed [WrapW-1:0] WrapPi = WrapW'(AngPi);
   localparam logic signed [CW-1:0] CordicGain = 33'sd652032874;

   localparam logic [CsrIdxW-1:0] RegThigh = 3'd0;
   localparam logic [CsrIdxW-1:0] RegShin = 3'd1;
   localparam logic [CsrIdxW-1:0] RegWheel = 3'd2;
   localparam logic [CsrIdxW-1:0] RegHipOff = 3'd3;
   localparam logic [CsrIdxW-1:0] RegKneeOff = 3'd4;
   localparam logic [CsrIdxW-1:0] RegLatOff = 3'd5;

   function automatic logic signed [AngW-1:0] atan_lookup(input int i);
      logic signed [AngW-1:0] v;
      begin
         case (i)
            0: v = 28'sd13176795;
            1: v = 28'sd7778716;
            2: v = 28'sd4110060;
            3: v = 28'sd2086331;
            4: v = 28'sd1047214;
            5: v = 28'sd524117;
            6: v = 28'sd262123;
            7: v = 28'sd131069;
            default: v = AngW'(28'sd65536 >>> (i - 8));
         endcase
         return v;
      end
   endfunction

endpackage

FILE: hdl/lwhk_reduce.sv
module lwhk_reduce (
   input  logic                               clock,
   input  logic signed [17:0]                 ang,
   output logic signed [lwhk_pkg::AngW-1:0]   red,
   output logic                               neg
);
   logic signed [lwhk_pkg::WrapW-1:0] wide;
   logic signed [lwhk_pkg::WrapW-1:0] turn;
   logic signed [lwhk_pkg::WrapW-1:0] r0;
   logic signed [lwhk_pkg::AngW-1:0] r1_ff, r1_in;
   logic                             neg_in;
   logic signed [lwhk_pkg::AngW-1:0] red_in;

   always_comb begin
      // The whole turns to remove are chosen by comparing against fixed thresholds in parallel.
      wide = {ang[17], ang, 12'd0};
      turn = '0;
      for (int j = 0; j < 5; j++) begin
         if (wide > lwhk_pkg::WrapPi + lwhk_pkg::WrapW'(j) * lwhk_pkg::WrapTwoPi) begin
            turn = lwhk_pkg::WrapW'(j + 1) * lwhk_pkg::WrapTwoPi;
         end
      end
      for (int j = 1; j < 6; j++) begin
         if (wide <= lwhk_pkg::WrapPi - lwhk_pkg::WrapW'(j) * lwhk_pkg::WrapTwoPi) begin
            turn = -(lwhk_pkg::WrapW'(j) * lwhk_pkg::WrapTwoPi);
         end
      end
      r0 = wide - turn;
      r1_in = lwhk_pkg::AngW'(r0);
   end

   always_ff @(posedge clock) begin
      r1_ff <= r1_in;
   end

   always_comb begin
      neg_in = 1'b0;
      red_in = r1_ff;
      if (r1_ff > lwhk_pkg::AngHalfPi) begin
         red_in = r1_ff - lwhk_pkg::AngPi;
         neg_in = 1'b1;
      end else if (r1_ff < -lwhk_pkg::AngHalfPi) begin
         red_in = r1_ff + lwhk_pkg::AngPi;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      red <= red_in;
      neg <= neg_in;
   end
endmodule

FILE: hdl/lwhk_cordic.sv
module lwhk_cordic (
   input  logic                               clock,
   input  logic signed [lwhk_pkg::AngW-1:0]   ang,
   input  logic                               neg,
   output logic signed [lwhk_pkg::CW-1:0]     sin_q,
   output logic signed [lwhk_pkg::CW-1:0]     cos_q
);
   logic signed [lwhk_pkg::CW-1:0]   x_ff [1:lwhk_pkg::CordicIters];
   logic signed [lwhk_pkg::CW-1:0]   y_ff [1:lwhk_pkg::CordicIters];
   logic signed [lwhk_pkg::AngW-1:0] z_ff [1:lwhk_pkg::CordicIters];
   logic                             n_ff [1:lwhk_pkg::CordicIters];

   for (genvar i = 0; i < lwhk_pkg::CordicIters; i++) begin : g_st
      logic signed [lwhk_pkg::CW-1:0]   x_cur, y_cur;
      logic signed [lwhk_pkg::AngW-1:0] z_cur;
      logic                             n_cur;
      if (i == 0) begin : g_head
         assign x_cur = lwhk_pkg::CordicGain;
         assign y_cur = '0;
         assign z_cur = ang;
         assign n_cur = neg;
      end else begin : g_tail
         assign x_cur = x_ff[i];
         assign y_cur = y_ff[i];
         assign z_cur = z_ff[i];
         assign n_cur = n_ff[i];
      end
      always_ff @(posedge clock) begin
         if (z_cur >= 0) begin
            x_ff[i+1] <= x_cur - (y_cur >>> i);
            y_ff[i+1] <= y_cur + (x_cur >>> i);
            z_ff[i+1] <= z_cur - lwhk_pkg::atan_lookup(i);
         end else begin
            x_ff[i+1] <= x_cur + (y_cur >>> i);
            y_ff[i+1] <= y_cur - (x_cur >>> i);
            z_ff[i+1] <= z_cur + lwhk_pkg::atan_lookup(i);
         end
         n_ff[i+1] <= n_cur;
      end
   end

   always_ff @(posedge clock) begin
      cos_q <= n_ff[lwhk_pkg::CordicIters] ? -x_ff[lwhk_pkg::CordicIters]
                                           : x_ff[lwhk_pkg::CordicIters];
      sin_q <= n_ff[lwhk_pkg::CordicIters] ? -y_ff[lwhk_pkg::CordicIters]
                                           : y_ff[lwhk_pkg::CordicIters];
   end
endmodule

FILE: hdl/leg_wheel_height_kinematics_unit.sv
// Takes one beat per clock cycle and never asserts busy, since the receiver cannot stall and
// the pipeline has no feedback. A beat accepted at one rising edge has its result on the rsp_
// ports with rsp_valid high for exactly one cycle: the first angle reduction register loads at
// the accepting edge, followed by the second reduction stage, the CordicStages + 1 CORDIC
// stages, the length products, the z products, the sums and the final rounding, each one a
// register. The configuration registers are read at several stages, so they must only be
// written while no beat is in flight.
module leg_wheel_height_kinematics_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [15:0]                   req_quat_w,
   input  logic signed [15:0]                   req_quat_x,
   input  logic signed [15:0]                   req_quat_y,
   input  logic signed [15:0]                   req_quat_z,
   input  logic signed [15:0]                   req_hip_angle,
   input  logic signed [15:0]                   req_knee_angle,
   output logic                                 rsp_valid,
   output logic signed [17:0]                   rsp_leg_height,
   output logic                                 rsp_lower_wheel,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lwhk_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [15:0]                          csr_data
);
   logic [15:0] thigh_ff, shin_ff, wheel_ff;
   logic signed [15:0] hipo_ff, kneeo_ff, lat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thigh_ff <= 16'd6658;
         shin_ff  <= 16'd5410;
         wheel_ff <= 16'd4162;
         hipo_ff  <= 16'sd0;
         kneeo_ff <= 16'sd0;
         lat_ff   <= -16'sd3064;
      end else if (csr_valid) begin
         case (csr_index)
            lwhk_pkg::RegThigh:   thigh_ff <= csr_data;
            lwhk_pkg::RegShin:    shin_ff <= csr_data;
            lwhk_pkg::RegWheel:   wheel_ff <= csr_data;
            lwhk_pkg::RegHipOff:  hipo_ff <= csr_data;
            lwhk_pkg::RegKneeOff: kneeo_ff <= csr_data;
            lwhk_pkg::RegLatOff:  lat_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy = 1'b0;

   logic signed [17:0] hip_a, sum_a;
   assign hip_a = 18'(req_hip_angle) + 18'(hipo_ff);
   assign sum_a = hip_a + 18'(req_knee_angle) + 18'(kneeo_ff);

   logic signed [lwhk_pkg::AngW-1:0] r1, r2;
   logic n1, n2;
   lwhk_reduce u_red1 (.clock(clock), .ang(hip_a), .red(r1), .neg(n1));
   lwhk_reduce u_red2 (.clock(clock), .ang(sum_a), .red(r2), .neg(n2));

   logic signed [lwhk_pkg::CW-1:0] s1, c1, s2, c2;
   lwhk_cordic u_c1 (.clock(clock), .ang(r1), .neg(n1), .sin_q(s1), .cos_q(c1));
   lwhk_cordic u_c2 (.clock(clock), .ang(r2), .neg(n2), .sin_q(s2), .cos_q(c2));

   // Quaternion z row, delayed to meet the CORDIC outputs.
   logic signed [33:0] r20_ff [lwhk_pkg::QuatDelay];
   logic signed [33:0] r21_ff [lwhk_pkg::QuatDelay];
   logic signed [33:0] r22_ff [lwhk_pkg::QuatDelay];
   logic [lwhk_pkg::QuatDelay-1:0] v_ff;
   always_ff @(posedge clock) begin
      r20_ff[0] <= (34'(req_quat_x) * req_quat_z - 34'(req_quat_w) * req_quat_y) <<< 1;
      r21_ff[0] <= (34'(req_quat_y) * req_quat_z + 34'(req_quat_w) * req_quat_x) <<< 1;
      r22_ff[0] <= 34'sd268435456
                  - ((34'(req_quat_x) * req_quat_x + 34'(req_quat_y) * req_quat_y) <<< 1);
      for (int k = 1; k < lwhk_pkg::QuatDelay; k++) begin
         r20_ff[k] <= r20_ff[k-1];
         r21_ff[k] <= r21_ff[k-1];
         r22_ff[k] <= r22_ff[k-1];
      end
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[lwhk_pkg::QuatDelay-2:0], start};
   end

   // Stage A: length products rounded to 2^-16 m.
   logic signed [49:0] pts, ptc, pss, psc;
   logic signed [19:0] ts_ff, tc_ff, ss_ff, sc_ff;
   logic signed [33:0] a20_ff, a21_ff, a22_ff;
   logic va_ff;
   always_comb begin
      pts = 50'(s1) * $signed({1'b0, thigh_ff}) + 50'sd536870912;
      ptc = 50'(c1) * $signed({1'b0, thigh_ff}) + 50'sd536870912;
      pss = 50'(s2) * $signed({1'b0, shin_ff}) + 50'sd536870912;
      psc = 50'(c2) * $signed({1'b0, shin_ff}) + 50'sd536870912;
   end
   always_ff @(posedge clock) begin
      ts_ff <= 20'(pts >>> 30);
      tc_ff <= 20'(ptc >>> 30);
      ss_ff <= 20'(pss >>> 30);
      sc_ff <= 20'(psc >>> 30);
      a20_ff <= r20_ff[lwhk_pkg::QuatDelay-1];
      a21_ff <= r21_ff[lwhk_pkg::QuatDelay-1];
      a22_ff <= r22_ff[lwhk_pkg::QuatDelay-1];
      va_ff <= reset ? 1'b0 : v_ff[lwhk_pkg::QuatDelay-1];
   end

   // Stage B: rotated z products.
   logic signed [21:0] ax, az, bx, bz;
   logic signed [52:0] pax, paz, pbx, pbz, py;
   logic vb_ff;
   assign ax = 22'(sc_ff) - 22'(ts_ff);
   assign az = -22'(tc_ff) - 22'(ss_ff);
   assign bx = -22'(sc_ff) - 22'(ts_ff);
   assign bz = -22'(tc_ff) + 22'(ss_ff);
   always_ff @(posedge clock) begin
      pax <= 53'(a20_ff) * ax;
      paz <= 53'(a22_ff) * az;
      pbx <= 53'(a20_ff) * bx;
      pbz <= 53'(a22_ff) * bz;
      py  <= 53'(a21_ff) * lat_ff;
      vb_ff <= reset ? 1'b0 : va_ff;
   end

   // Stage C: sums of the z products.
   logic signed [54:0] za, zb, za_ff, zb_ff;
   logic vc_ff;
   always_comb begin
      za = 55'(pax) + 55'(py) + 55'(paz);
      zb = 55'(pbx) + 55'(py) + 55'(pbz);
   end
   always_ff @(posedge clock) begin
      za_ff <= za;
      zb_ff <= zb;
      vc_ff <= reset ? 1'b0 : vb_ff;
   end

   // Stage D: compare, round and saturate.
   logic signed [54:0] zm, hw;
   logic lw;
   always_comb begin
      lw = zb_ff < za_ff;
      zm = lw ? zb_ff : za_ff;
      hw = ((-zm + 55'sd134217728) >>> 28) + 55'($signed({1'b0, wheel_ff}));
   end
   always_ff @(posedge clock) begin
      rsp_valid <= reset ? 1'b0 : vc_ff;
      rsp_lower_wheel <= lw;
      if (hw > 55'sd131071) rsp_leg_height <= 18'sd131071;
      else if (hw < -55'sd131072) rsp_leg_height <= -18'sd131072;
      else rsp_leg_height <= 18'(hw);
   end
endmodule

FILE: dv/leg_wheel_height_kinematics_unit_test.sv
module leg_wheel_height_kinematics_unit_test;

   typedef struct {
      logic signed [15:0] qw, qx, qy, qz, hip, knee;
   } joint_sample_type;

   typedef struct {
      logic signed [17:0] height;
      logic lower;
   } height_type;

   localparam longint TwoPi = 105414357;
   localparam longint HalfTurn = 52707179;
   localparam longint QuarterTurn = 26353589;
   localparam longint GainQ30 = 652032874;
   localparam int CycleLimit = 400000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [15:0] req_quat_w = 0, req_quat_x = 0, req_quat_y = 0, req_quat_z = 0;
   logic signed [15:0] req_hip_angle = 0, req_knee_angle = 0;
   logic rsp_valid;
   logic signed [17:0] rsp_leg_height;
   logic rsp_lower_wheel;
   logic csr_valid = 0;
   logic csr_ready;
   logic [lwhk_pkg::CsrIdxW-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   logic [15:0] thigh_len, shin_len, wheel_rad, hip_off, knee_off, lat_off;
   height_type pending_heights[$];
   int failures = 0;
   int cycles = 0;
   int sender_idle_pct = 0;

   leg_wheel_height_kinematics_unit dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("leg_wheel_height_kinematics_unit: mismatch");
         $finish;
      end
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_q30(longint v);
      return floor_shift(v + (longint'(1) << 29), 30);
   endfunction

   function automatic void cordic_sincos(input longint a12, output longint s, output longint c);
      longint atans[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                            131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2};
      longint r, x, y, dx, dy;
      bit flip;
      r = (a12 * 4096) % TwoPi;
      x = GainQ30;
      y = 0;
      flip = 0;
      if (r < 0) r += TwoPi;
      if (r > HalfTurn) r -= TwoPi;
      if (r > QuarterTurn) begin
         r -= HalfTurn;
         flip = 1;
      end else if (r < -QuarterTurn) begin
         r += HalfTurn;
         flip = 1;
      end
      for (int i = 0; i < lwhk_pkg::CordicStages && i < 24; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (r >= 0) begin
            x -= dx;
            y += dy;
            r -= atans[i];
         end else begin
            x += dx;
            y -= dy;
            r += atans[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic height_type predict_height(joint_sample_type js);
      longint qw, qx, qy, qz, hip, knee, lt, ls, yo;
      longint s1, c1, s2, c2, ts, tc, ss, sc, ax, az, bx, bz, r20, r21, r22, za, zb, zmin, h;
      height_type res;
      qw = js.qw;
      qx = js.qx;
      qy = js.qy;
      qz = js.qz;
      hip = longint'(js.hip) + longint'($signed(hip_off));
      knee = longint'(js.knee) + longint'($signed(knee_off));
      lt = thigh_len;
      ls = shin_len;
      yo = longint'($signed(lat_off));
      cordic_sincos(hip, s1, c1);
      cordic_sincos(hip + knee, s2, c2);
      ts = round_q30(lt * s1);
      tc = round_q30(lt * c1);
      ss = round_q30(ls * s2);
      sc = round_q30(ls * c2);
      ax = sc - ts;
      az = -tc - ss;
      bx = -sc - ts;
      bz = -tc + ss;
      r20 = 2 * (qx * qz - qw * qy);
      r21 = 2 * (qy * qz + qw * qx);
      r22 = (longint'(1) << 28) - 2 * (qx * qx + qy * qy);
      za = r20 * ax + r21 * yo + r22 * az;
      zb = r20 * bx + r21 * yo + r22 * bz;
      if (zb < za) begin
         zmin = zb;
         res.lower = 1;
      end else begin
         zmin = za;
         res.lower = 0;
      end
      h = floor_shift(-zmin + (longint'(1) << 27), 28) + longint'(wheel_rad);
      if (h > 131071) h = 131071;
      if (h < -131072) h = -131072;
      res.height = h[17:0];
      return res;
   endfunction

   always @(posedge clock) begin
      height_type exp_h;
      if (!reset && rsp_valid) begin
         if (pending_heights.size() == 0) begin
            $display("%0t: unexpected result height %0d lower %0d", $time,
                     rsp_leg_height, rsp_lower_wheel);
            failures++;
         end else begin
            exp_h = pending_heights.pop_front();
            if (rsp_leg_height !== exp_h.height) begin
               $display("%0t: leg_height expected %0d actual %0d", $time,
                        exp_h.height, rsp_leg_height);
               failures++;
            end
            if (rsp_lower_wheel !== exp_h.lower) begin
               $display("%0t: lower_wheel expected %0d actual %0d", $time,
                        exp_h.lower, rsp_lower_wheel);
               failures++;
            end
         end
      end
   end

   task automatic send_beat(joint_sample_type js);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start <= 0;
      end
      @(negedge clock);
      start <= 1;
      req_quat_w <= js.qw;
      req_quat_x <= js.qx;
      req_quat_y <= js.qy;
      req_quat_z <= js.qz;
      req_hip_angle <= js.hip;
      req_knee_angle <= js.knee;
      while (busy) @(negedge clock);
      @(posedge clock);
      pending_heights = {pending_heights, predict_height(js)};
   endtask

   task automatic drain;
      @(negedge clock);
      start <= 0;
      while (pending_heights.size() != 0) @(posedge clock);
      repeat (lwhk_pkg::CordicStages + 12) @(posedge clock);
   endtask

   task automatic write_reg(logic [lwhk_pkg::CsrIdxW-1:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         lwhk_pkg::RegThigh: thigh_len = value;
         lwhk_pkg::RegShin: shin_len = value;
         lwhk_pkg::RegWheel: wheel_rad = value;
         lwhk_pkg::RegHipOff: hip_off = value;
         lwhk_pkg::RegKneeOff: knee_off = value;
         lwhk_pkg::RegLatOff: lat_off = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic write_all(logic [15:0] t, logic [15:0] s, logic [15:0] w,
                            logic [15:0] ho, logic [15:0] ko, logic [15:0] lo);
      write_reg(lwhk_pkg::RegThigh, t);
      write_reg(lwhk_pkg::RegShin, s);
      write_reg(lwhk_pkg::RegWheel, w);
      write_reg(lwhk_pkg::RegHipOff, ho);
      write_reg(lwhk_pkg::RegKneeOff, ko);
      write_reg(lwhk_pkg::RegLatOff, lo);
   endtask

   function automatic joint_sample_type make_sample(int w, int x, int y, int z, int h, int k);
      joint_sample_type js;
      js.qw = 16'(w);
      js.qx = 16'(x);
      js.qy = 16'(y);
      js.qz = 16'(z);
      js.hip = 16'(h);
      js.knee = 16'(k);
      return js;
   endfunction

   function automatic logic signed [15:0] rand_quat_part();
      case ($urandom_range(5))
         0: return 16'(int'($urandom_range(32768)) - 16384);
         1: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
         default: return 16'(int'($urandom_range(2000)) - 1000);
      endcase
   endfunction

   function automatic joint_sample_type rand_sample();
      joint_sample_type js;
      js.qw = ($urandom_range(3) == 0) ? rand_quat_part() : 16'(16384 - $urandom_range(800));
      js.qx = rand_quat_part();
      js.qy = rand_quat_part();
      js.qz = rand_quat_part();
      js.hip = $urandom_range(3) == 0 ? 16'($urandom) : 16'(int'($urandom_range(12868)) - 6434);
      js.knee = $urandom_range(3) == 0 ? 16'($urandom) : 16'(int'($urandom_range(12868)) - 6434);
      return js;
   endfunction

   task automatic test_directed;
      send_beat(make_sample(16384, 0, 0, 0, 0, 0));
      send_beat(make_sample(-16384, 0, 0, 0, 0, 0));
      send_beat(make_sample(0, 16384, 0, 0, 0, 0));
      send_beat(make_sample(0, 0, -16384, 0, 6434, 0));
      send_beat(make_sample(0, 0, 0, 16384, -6434, 3217));
      send_beat(make_sample(16384, 16384, 16384, 16384, 32767, -32768));
      send_beat(make_sample(-16384, -16384, -16384, -16384, -32768, 32767));
      send_beat(make_sample(16384, 0, 0, 0, 12868, 0));
      send_beat(make_sample(16384, 0, 0, 0, -12868, 12868));
      send_beat(make_sample(16384, 0, 0, 0, 6434, 6434));
      send_beat(make_sample(11585, 0, 11585, 0, 1000, -2000));
      send_beat(make_sample(-1, 1, -1, 1, -1, -1));
      drain();
   endtask

   task automatic test_saturation;
      write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF);
      send_beat(make_sample(16384, 0, 0, 0, -32767, 32767));
      send_beat(make_sample(16384, 0, 0, 0, 0, 0));
      drain();
      write_all(16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000);
      send_beat(make_sample(0, 16384, 16384, 0, 0, 0));
      send_beat(make_sample(16384, 16384, 16384, 0, 32767, 0));
      drain();
      write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_beat(make_sample(16384, 0, 0, 0, 100, 200));
      send_beat(make_sample(0, 0, 0, 0, 0, 0));
      drain();
   endtask

   task automatic test_ignored_index;
      write_reg(lwhk_pkg::CsrIdxW'(6), 16'h1234);
      write_reg(lwhk_pkg::CsrIdxW'(7), 16'hBEEF);
      send_beat(make_sample(16384, 0, 0, 0, 500, -500));
      drain();
   endtask

   task automatic test_random(int idle_pct, int phases, int per_phase);
      sender_idle_pct = idle_pct;
      for (int p = 0; p < phases; p++) begin
         write_all(16'($urandom_range(20000)), 16'($urandom_range(20000)),
                   16'($urandom_range(65535)), 16'($urandom), 16'($urandom),
                   16'($urandom));
         if (p == 0) write_all(16'd6658, 16'd5410, 16'd4162, 16'd0, 16'd0, -16'sd3064);
         repeat (per_phase) send_beat(rand_sample());
         drain();
      end
      sender_idle_pct = 0;
   endtask

   initial begin
      thigh_len = 16'd6658;
      shin_len = 16'd5410;
      wheel_rad = 16'd4162;
      hip_off = '0;
      knee_off = '0;
      lat_off = -16'sd3064;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_saturation();
      test_ignored_index();
      test_random(33, 4, 83);
      test_random(49, 4, 83);
      test_random(0, 4, 84);
      if (failures == 0) begin
         $display("leg_wheel_height_kinematics_unit: match");
      end else begin
         $display("leg_wheel_height_kinematics_unit: mismatch");
      end
      $finish;
   end

endmodule
